/* sv/scanline_flood_fill_assert.svh */
// assertion macros for the scanline flood-fill block
`ifndef SCANLINE_FLOOD_FILL_ASSERT_SVH
`define SCANLINE_FLOOD_FILL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sff_pkg.sv */
// shared constants and codes for the scanline flood-fill block
`default_nettype none
package sff_pkg;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STACK_DEPTH = 1024;
  localparam int PIXEL_BITS  = 32;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FA_W        = $clog2(FRAME_DEPTH);
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [16:0]           paint_cnt_t;

  localparam paint_cnt_t PAINT_MAX = 17'h1FFFF;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  // status codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_OUTSIDE = 2'd1;
  localparam logic [1:0] STS_OVF     = 2'd2;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

/* sv/scanline_flood_fill.sv */
// Scanline flood-fill engine over a 256x256 frame of 32-bit pixels. An item is taken
// when start is high and busy is low; its single result appears for exactly one cycle
// with out_valid and cannot be held off. A write answers the cycle after it is taken,
// a read after its RAM read and S_RD_WAIT. A fill uses one frame RAM port: a popped
// seed takes a stack and a frame read, a leftward step one read, a painted pixel a
// read, a write and up to two neighbour reads. Duration follows region size; busy stays
// high until the result is shown. Frame and seed stack RAMs are not cleared after reset.
`default_nettype none
module scanline_flood_fill
  import sff_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   in_command,
  input  wire logic [7:0]   in_x,
  input  wire logic [7:0]   in_y,
  input  wire logic [31:0]  in_pixel_value,
  output logic              out_valid,
  output logic [31:0]       out_read_value,
  output logic [1:0]        out_status,
  output logic [16:0]       out_pixels_painted,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [8:0]   cfg_data
);
`include "scanline_flood_fill_assert.svh"

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RD_WAIT   = 4'd1;
  localparam logic [3:0] S_F_ORIG    = 4'd2;
  localparam logic [3:0] S_POP       = 4'd3;
  localparam logic [3:0] S_POP_W     = 4'd4;
  localparam logic [3:0] S_CHK_SEED  = 4'd5;
  localparam logic [3:0] S_LEFT_RD   = 4'd6;
  localparam logic [3:0] S_LEFT      = 4'd7;
  localparam logic [3:0] S_SPAN_RD   = 4'd8;
  localparam logic [3:0] S_SPAN_CHK  = 4'd9;
  localparam logic [3:0] S_UP_RD     = 4'd10;
  localparam logic [3:0] S_UP_CHK    = 4'd11;
  localparam logic [3:0] S_DN_RD     = 4'd12;
  localparam logic [3:0] S_DN_CHK    = 4'd13;

  logic [3:0]   state_r, state_nxt;
  logic [8:0]   w_r, h_r;
  pixel_t       colour_r, colour_nxt;
  pixel_t       orig_r, orig_nxt;
  logic [8:0]   cx_r, cx_nxt;
  logic [7:0]   cy_r, cy_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  paint_cnt_t   cnt_r, cnt_nxt;
  logic         up_r, up_nxt, dn_r, dn_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_rv_r, out_rv_nxt;
  logic [1:0]   out_st_r, out_st_nxt;
  paint_cnt_t   out_pc_r, out_pc_nxt;

  // memory ports
  pixel_t       frame_mem [FRAME_DEPTH];
  logic [15:0]  stack_mem [STACK_DEPTH];
  logic         fr_we, fr_re;
  logic [FA_W-1:0] fr_addr;
  pixel_t       fr_wdata, fr_rdata;
  logic         st_we, st_re;
  logic [SA_W-1:0] st_addr;
  logic [15:0]  st_wdata, st_rdata;

  logic [8:0]   eff_w, eff_h;
  logic         in_image, eq;
  logic [SP_W-1:0] sp_dec;
  logic [8:0]   cy_inc;

  assign eff_w    = (w_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : w_r;
  assign eff_h    = (h_r > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : h_r;
  assign in_image = ({1'b0, in_x} < eff_w) && ({1'b0, in_y} < eff_h);
  assign eq       = (fr_rdata == orig_r);
  assign sp_dec   = sp_r - SP_W'(1);
  assign cy_inc   = {1'b0, cy_r} + 9'd1;

  assign busy               = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rv_r;
  assign out_status         = out_st_r;
  assign out_pixels_painted = out_pc_r;

  // frame store, one port, registered read
  always_ff @(posedge clk) begin
    if (fr_we) frame_mem[fr_addr] <= fr_wdata;
    if (fr_re) fr_rdata <= frame_mem[fr_addr];
  end

  // seed stack, registered read
  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_addr] <= st_wdata;
    if (st_re) st_rdata <= stack_mem[st_addr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    colour_nxt    = colour_r;
    orig_nxt      = orig_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    sp_nxt        = sp_r;
    cnt_nxt       = cnt_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    out_pc_nxt    = out_pc_r;
    fr_we         = 1'b0;
    fr_re         = 1'b0;
    fr_addr       = {cy_r, cx_r[7:0]};
    fr_wdata      = colour_r;
    st_we         = 1'b0;
    st_re         = 1'b0;
    st_addr       = sp_r[SA_W-1:0];
    st_wdata      = {cy_r, cx_r[7:0]};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_rv_nxt = '0;
          out_st_nxt = in_image ? STS_DONE : STS_OUTSIDE;
          out_pc_nxt = '0;
          fr_addr    = {in_y, in_x};
          fr_wdata   = in_pixel_value;
          case (in_command)
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              fr_we         = in_image;
            end
            CMD_READ: begin
              if (in_image) begin
                fr_re     = 1'b1;
                state_nxt = S_RD_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_FILL: begin
              if (in_image) begin
                fr_re      = 1'b1;
                colour_nxt = in_pixel_value;
                cx_nxt     = {1'b0, in_x};
                cy_nxt     = in_y;
                cnt_nxt    = '0;
                state_nxt  = S_F_ORIG;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_st_nxt    = STS_DONE;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_rv_nxt    = fr_rdata;
        state_nxt     = S_IDLE;
      end
      S_F_ORIG: begin
        orig_nxt = fr_rdata;
        if (fr_rdata == colour_r) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = fr_rdata;
          out_st_nxt    = STS_DONE;
          out_pc_nxt    = '0;
          state_nxt     = S_IDLE;
        end else begin
          // push the seed itself
          st_we     = 1'b1;
          st_addr   = '0;
          sp_nxt    = SP_W'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = orig_r;
          out_st_nxt    = STS_DONE;
          out_pc_nxt    = cnt_r;
          state_nxt     = S_IDLE;
        end else begin
          sp_nxt    = sp_dec;
          st_re     = 1'b1;
          st_addr   = sp_dec[SA_W-1:0];
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        cx_nxt    = {1'b0, st_rdata[7:0]};
        cy_nxt    = st_rdata[15:8];
        fr_re     = 1'b1;
        fr_addr   = st_rdata;
        up_nxt    = 1'b0;
        dn_nxt    = 1'b0;
        state_nxt = S_CHK_SEED;
      end
      S_CHK_SEED: begin
        state_nxt = eq ? S_LEFT_RD : S_POP;
      end
      // walk left to the start of the span
      S_LEFT_RD: begin
        if (cx_r != '0) begin
          fr_re     = 1'b1;
          fr_addr   = {cy_r, 8'(cx_r - 9'd1)};
          state_nxt = S_LEFT;
        end else begin
          state_nxt = S_SPAN_RD;
        end
      end
      S_LEFT: begin
        if (eq) begin
          cx_nxt    = cx_r - 9'd1;
          state_nxt = S_LEFT_RD;
        end else begin
          state_nxt = S_SPAN_RD;
        end
      end
      // paint rightward
      S_SPAN_RD: begin
        if (cx_r < eff_w) begin
          fr_re     = 1'b1;
          state_nxt = S_SPAN_CHK;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_SPAN_CHK: begin
        if (eq) begin
          fr_we     = 1'b1;
          cnt_nxt   = (cnt_r == PAINT_MAX) ? cnt_r : cnt_r + 17'd1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_UP_RD: begin
        if (cy_r != '0) begin
          fr_re     = 1'b1;
          fr_addr   = {8'(cy_r - 8'd1), cx_r[7:0]};
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_CHK: begin
        state_nxt = S_DN_RD;
        if (!up_r && eq) begin
          if (sp_r == SP_W'(STACK_DEPTH)) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = orig_r;
            out_st_nxt    = STS_OVF;
            out_pc_nxt    = cnt_r;
            sp_nxt        = '0;
            state_nxt     = S_IDLE;
          end else begin
            st_we    = 1'b1;
            st_wdata = {8'(cy_r - 8'd1), cx_r[7:0]};
            sp_nxt   = sp_r + SP_W'(1);
            up_nxt   = 1'b1;
          end
        end else if (up_r && !eq) begin
          up_nxt = 1'b0;
        end
      end
      S_DN_RD: begin
        if (cy_inc < eff_h) begin
          fr_re     = 1'b1;
          fr_addr   = {cy_inc[7:0], cx_r[7:0]};
          state_nxt = S_DN_CHK;
        end else begin
          cx_nxt    = cx_r + 9'd1;
          state_nxt = S_SPAN_RD;
        end
      end
      S_DN_CHK: begin
        cx_nxt    = cx_r + 9'd1;
        state_nxt = S_SPAN_RD;
        if (!dn_r && eq) begin
          if (sp_r == SP_W'(STACK_DEPTH)) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = orig_r;
            out_st_nxt    = STS_OVF;
            out_pc_nxt    = cnt_r;
            sp_nxt        = '0;
            state_nxt     = S_IDLE;
          end else begin
            st_we    = 1'b1;
            st_wdata = {cy_inc[7:0], cx_r[7:0]};
            sp_nxt   = sp_r + SP_W'(1);
            dn_nxt   = 1'b1;
          end
        end else if (dn_r && !eq) begin
          dn_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      w_r         <= 9'(MAX_WIDTH);
      h_r         <= 9'(MAX_HEIGHT);
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH)  w_r <= cfg_data;
        if (cfg_index == REG_HEIGHT) h_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
    orig_r   <= orig_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cnt_r    <= cnt_nxt;
    up_r     <= up_nxt;
    dn_r     <= dn_nxt;
    out_rv_r <= out_rv_nxt;
    out_st_r <= out_st_nxt;
    out_pc_r <= out_pc_nxt;
  end

  // checks
  `SFF_ASSERT_NEXT(a_accept_progress, start && !busy, out_valid || busy, "item accepted without progress")
  `SFF_ASSERT_NOW(a_busy_end_result, $fell(busy), out_valid, "fill or read ended without result")
  `SFF_ASSERT_NOW(a_stack_bound, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "seed stack count overrun")
  `SFF_ASSERT_NOW(a_idle_stack_empty, !busy, sp_r == '0, "seed stack not cleared after fill")

endmodule
`default_nettype wire
